[hw/rtl/slid_pkg.sv]
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants for the sorted record list.
// ----------------------------------------------------------------------------
package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int SCORE_W  = 32;
   localparam int RCNT_W   = 5;

   typedef enum logic [0:0] {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } slid_func_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } slid_status_type;

   typedef struct packed {
      slid_func_type        func;
      logic [KEY_W-1:0]     key;
      logic [SCORE_W-1:0]   score_bits;
   } slid_req_type;

   typedef struct packed {
      slid_status_type      status;
      logic [RCNT_W-1:0]    record_count;
   } slid_rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [SCORE_W-1:0]   score;
   } slid_rec_type;

   typedef struct packed {
      logic                 do_ins;
      logic                 do_del;
      logic [KEY_W-1:0]     key;
      logic [SCORE_W-1:0]   score;
   } slid_ctl_type;

endpackage

[hw/rtl/sorted_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top
// Sorted record list built as a row of slot cells; inserts and deletes by key.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      beat taken when start && !busy
//   response  rsp_strobe, rsp_data       one-cycle strobe per beat, no back-pressure
//
// Every slot compares in parallel and the whole row shifts at once, so one
// request beat is taken each cycle; busy stays low.
// The response leaves the output register in the cycle after its request beat.
// Synchronous reset empties the list (slot valid bits, count and response strobe only).
// The receiver cannot stall; nothing is buffered beyond one response.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  slid_pkg::slid_req_type req_data,
   output logic                  rsp_strobe,
   output slid_pkg::slid_rsp_type rsp_data
);
   import slid_pkg::*;

   slid_ctl_type              ctl;
   slid_rec_type              recs [CAPACITY];
   logic [CAPACITY-1:0]       ge_vec;
   logic [CAPACITY-1:0]       hit_vec;
   logic                      accept;
   logic                      found;
   logic                      full;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   slid_status_type           status_in;
   logic                      rsp_strobe_ff;
   slid_rsp_type              rsp_ff;
   slid_rec_type              empty_rec;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign found     = |hit_vec;
   assign full      = count_ff >= CNT_W'(CAPACITY);
   assign empty_rec = '0;

   always_comb begin
      ctl.key    = req_data.key;
      ctl.score  = req_data.score_bits;
      ctl.do_ins = accept && (req_data.func == FUNC_INSERT) && !full;
      ctl.do_del = accept && (req_data.func == FUNC_DELETE) && found;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slid_rec_type l_rec;
      slid_rec_type r_rec;
      logic         l_ge;
      if (i == 0) begin : g_first
         assign l_rec = empty_rec;
         assign l_ge  = 1'b0;
      end else begin : g_mid
         assign l_rec = recs[i-1];
         assign l_ge  = ge_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign r_rec = empty_rec;
      end else begin : g_body
         assign r_rec = recs[i+1];
      end
      slid_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .left_rec  (l_rec),
         .left_ge   (l_ge),
         .right_rec (r_rec),
         .rec       (recs[i]),
         .ge        (ge_vec[i]),
         .hit       (hit_vec[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_INSERTED;
      if (req_data.func == FUNC_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
            count_in  = count_ff + CNT_W'(1);
         end
      end else begin
         if (found) begin
            status_in = ST_DELETED;
            count_in  = count_ff - CNT_W'(1);
         end else begin
            status_in = ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.status       <= status_in;
         rsp_ff.record_count <= RCNT_W'(count_in);
      end
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hw/rtl/slid_cell.sv]
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted list: holds a record, compares it against the
// command key and loads its own, the new or a neighbor's record.
// ----------------------------------------------------------------------------
module slid_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  slid_pkg::slid_ctl_type ctl,
   input  slid_pkg::slid_rec_type left_rec,
   input  logic                  left_ge,
   input  slid_pkg::slid_rec_type right_rec,
   output slid_pkg::slid_rec_type rec,
   output logic                  ge,
   output logic                  hit
);
   import slid_pkg::*;

   slid_rec_type rec_ff;
   slid_rec_type rec_in;
   logic         key_ge;

   assign key_ge = rec_ff.key >= ctl.key;
   assign ge     = !rec_ff.valid || key_ge;
   assign hit    = rec_ff.valid && (rec_ff.key == ctl.key);
   assign rec    = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.do_ins) begin
         if (ge && !left_ge) begin
            rec_in.valid = 1'b1;
            rec_in.key   = ctl.key;
            rec_in.score = ctl.score;
         end else if (ge) begin
            rec_in = left_rec;
         end
      end else if (ctl.do_del) begin
         if (rec_ff.valid && key_ge) begin
            rec_in = right_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff.key   <= rec_in.key;
      rec_ff.score <= rec_in.score;
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else begin
         rec_ff.valid <= rec_in.valid;
      end
   end

endmodule

[tb/sv/sorted_list_insert_delete_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top_tb
// Self-checking bench for the sorted record list.
//
// Request beats are queued up front: a short directed opening, then about a
// thousand random inserts and deletes. The opening covers an empty-list
// delete, extreme keys and scores, duplicate keys, filling the list to
// capacity and an insert into a full list. The random part runs in blocks
// that lean toward insert or delete, so the count swings between empty and
// full. Keys mostly come from a small pool, so deletes often hit.
// A shadow list tracks every accepted beat and predicts status and count.
// Each response strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_top_tb;
   import slid_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 1030;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      slid_req_type req;
      int           gap;
      bit           drain_first;
   } list_beat_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         start      = 1'b0;
   slid_req_type req_data   = '0;
   logic         busy;
   logic         rsp_strobe;
   slid_rsp_type rsp_data;

   list_beat_type beat_queue[$];
   slid_rsp_type  outcome_queue[$];
   list_beat_type next_beat;
   slid_rsp_type  want;
   int            idle_left      = 0;
   int            cycle_count    = 0;
   int            mismatch_count = 0;

   logic [KEY_W-1:0]   list_keys[CAPACITY];
   logic [SCORE_W-1:0] list_scores[CAPACITY];
   int                 list_count = 0;

   sorted_list_insert_delete_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic slid_rsp_type apply_list_op(slid_req_type op);
      slid_rsp_type res;
      int           pos;
      pos = 0;
      if (op.func == FUNC_INSERT) begin
         if (list_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            while (pos < list_count && list_keys[pos] < op.key) pos++;
            for (int i = list_count; i > pos; i--) begin
               list_keys[i]   = list_keys[i-1];
               list_scores[i] = list_scores[i-1];
            end
            list_keys[pos]   = op.key;
            list_scores[pos] = op.score_bits;
            list_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         while (pos < list_count && list_keys[pos] != op.key) pos++;
         if (pos >= list_count) begin
            res.status = ST_NOT_FOUND;
         end else begin
            for (int i = pos; i + 1 < list_count; i++) begin
               list_keys[i]   = list_keys[i+1];
               list_scores[i] = list_scores[i+1];
            end
            list_count--;
            list_keys[list_count]   = '0;
            list_scores[list_count] = '0;
            res.status = ST_DELETED;
         end
      end
      res.record_count = RCNT_W'(list_count);
      return res;
   endfunction

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return KEY_W'($urandom_range(0, 15));
      if (r < 68) return '0;
      if (r < 76) return '1;
      if (r < 82) return {{(KEY_W-4){1'b1}}, 4'($urandom_range(0, 15))};
      return KEY_W'($urandom);
   endfunction

   function automatic logic [SCORE_W-1:0] pick_score();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return SCORE_W'($urandom);
   endfunction

   task automatic queue_beat(slid_func_type func, logic [KEY_W-1:0] key,
                             logic [SCORE_W-1:0] score, int gap, bit drain_first);
      list_beat_type b;
      b.req.func       = func;
      b.req.key        = key;
      b.req.score_bits = score;
      b.gap            = gap;
      b.drain_first    = drain_first;
      beat_queue.push_back(b);
   endtask

   task automatic report_mismatch(string msg);
      $display("cycle %0d: mismatch: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) outcome_queue.push_back(apply_list_op(req_data));
         if (start && busy) begin
            // hold the beat
         end else if (idle_left > 0) begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (beat_queue.size() > 0 &&
                      (!beat_queue[0].drain_first || outcome_queue.size() == 0)) begin
            next_beat = beat_queue.pop_front();
            req_data  <= next_beat.req;
            start     <= 1'b1;
            idle_left <= next_beat.gap;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (outcome_queue.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.record_count !== want.record_count)
               report_mismatch($sformatf("record_count %0d, expected %0d",
                                         rsp_data.record_count, want.record_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle %0d: timeout", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int  ins_pct;
      bit  burst;
      slid_func_type f;

      queue_beat(FUNC_DELETE, 32'd9, '0, draw_gap(0), 1'b0);
      queue_beat(FUNC_INSERT, '1, '0, draw_gap(0), 1'b0);
      queue_beat(FUNC_INSERT, '0, '1, draw_gap(0), 1'b0);
      queue_beat(FUNC_INSERT, 32'd5, 32'h3F80_0000, draw_gap(0), 1'b0);
      queue_beat(FUNC_INSERT, 32'd5, 32'hBF80_0000, draw_gap(0), 1'b0);
      queue_beat(FUNC_DELETE, 32'd5, '1, draw_gap(0), 1'b0);
      queue_beat(FUNC_DELETE, 32'd7, '0, draw_gap(0), 1'b0);
      for (int i = 13; i >= 1; i--)
         queue_beat(FUNC_INSERT, KEY_W'(i) * 32'h1111_1111, pick_score(),
                    draw_gap(i > 6), 1'b0);
      // insert into a full list after the pipe drains
      queue_beat(FUNC_INSERT, 32'd3, 32'h7F80_0000, draw_gap(0), 1'b1);
      queue_beat(FUNC_DELETE, '1, '0, draw_gap(0), 1'b0);
      queue_beat(FUNC_DELETE, '0, '0, draw_gap(0), 1'b0);

      ins_pct = 50;
      burst   = 1'b0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: ins_pct = 85;
               1: ins_pct = 20;
               default: ins_pct = 50;
            endcase
            burst = ($urandom_range(0, 2) == 0);
         end
         f = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
         queue_beat(f, pick_key(), pick_score(), draw_gap(burst), (n % 150 == 75));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (beat_queue.size() > 0 || start || outcome_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outcome_queue.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", outcome_queue.size()));

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/slid_pkg.sv
hw/rtl/slid_cell.sv
hw/rtl/sorted_list_insert_delete_top.sv
tb/sv/sorted_list_insert_delete_top_tb.sv
